// File: rtl/core/rau_pkg.sv
// shared types and constants of the rational arithmetic unit
package rau_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_EQ  = 3'd4;
  localparam logic [2:0] OP_NEG = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL0,
    CMD_MUL1,
    CMD_MUL2,
    CMD_MUL3,
    CMD_GCD_INIT,
    CMD_GCD_STEP,
    CMD_DIVN_INIT,
    CMD_DIVD_INIT,
    CMD_DIV_STEP,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    logic trivial;
    logic gcd_done;
    logic div_done;
  } sts_t;

endpackage

// File: rtl/core/rau_dp.sv
// datapath: shared multiplier, binary gcd and restoring divider
module rau_dp import rau_pkg::*; #(
  parameter int PART_WIDTH = 32
) (
  input  logic        clk_i,
  input  cmd_e        cmd_i,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] a_num_i,
  input  logic [30:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [30:0] b_den_i,
  output sts_t        sts_o,
  output logic [31:0] res_num_o,
  output logic [30:0] res_den_o,
  output logic        is_equal_o,
  output logic [1:0]  status_o
);

  localparam logic [63:0] Lim = (64'd1 << (PART_WIDTH - 1)) - 64'd1;

  logic [2:0]  op_q;
  logic [31:0] an_q, bn_q;
  logic [30:0] ad_q, bd_q;
  logic [63:0] prod_q;
  logic        psign_q;
  logic [63:0] num_q;
  logic [63:0] den_q;
  logic        dsign_q;
  logic [63:0] u_q, v_q;
  logic [5:0]  k_q;
  logic [63:0] gd_q, dvd_q, rem_q, qn_q;
  logic [6:0]  cnt_q;
  logic [31:0] res_num_q;
  logic [30:0] res_den_q;
  logic        eq_q;
  logic [1:0]  st_q;

  logic [31:0] an_mag, bn_mag, mx, my;
  logic        mxs, mys;
  logic [63:0] sprod, num_mag, gcd_val, qd;
  logic [64:0] rs;
  logic        ge, neg, div0, ovf, eq;

  assign an_mag = an_q[31] ? (32'd0 - an_q) : an_q;
  assign bn_mag = bn_q[31] ? (32'd0 - bn_q) : bn_q;

  // operand selection for the shared multiplier
  always_comb begin
    mx  = an_mag;
    mxs = an_q[31];
    my  = {1'b0, bd_q};
    mys = 1'b0;
    case (cmd_i)
      CMD_MUL0: begin
        mx  = an_mag;
        mxs = an_q[31] ^ (op_q == OP_NEG);
        if (op_q == OP_MUL) begin
          my  = bn_mag;
          mys = bn_q[31];
        end else if (op_q == OP_NEG) begin
          my  = 32'd1;
        end
      end
      CMD_MUL1: begin
        mx  = bn_mag;
        mxs = bn_q[31] ^ (op_q == OP_SUB);
        my  = (op_q == OP_ADD || op_q == OP_SUB) ? {1'b0, ad_q} : 32'd0;
      end
      CMD_MUL2: begin
        mx  = {1'b0, ad_q};
        mxs = 1'b0;
        if (op_q == OP_DIV) begin
          my  = bn_mag;
          mys = bn_q[31];
        end else if (op_q == OP_NEG) begin
          my  = 32'd1;
        end
      end
      default: begin
        mx = an_mag;
      end
    endcase
  end

  assign sprod   = psign_q ? (64'd0 - prod_q) : prod_q;
  assign num_mag = num_q[63] ? (64'd0 - num_q) : num_q;
  assign neg     = num_q[63] ^ dsign_q;
  assign gcd_val = v_q << k_q;
  assign rs      = {rem_q, dvd_q[63]};
  assign ge      = rs >= {1'b0, gd_q};
  assign qd      = dvd_q;

  assign div0 = ((op_q == OP_ADD || op_q == OP_SUB || op_q == OP_MUL || op_q == OP_DIV)
                 && (ad_q == 31'd0 || bd_q == 31'd0))
             || (op_q == OP_DIV && bn_q == 32'd0)
             || (op_q == OP_NEG && ad_q == 31'd0);
  assign eq   = (an_q == bn_q) && (ad_q == bd_q);
  assign ovf  = (qd > Lim) || (qn_q > (neg ? Lim + 64'd1 : Lim));

  assign sts_o.trivial  = (op_q == OP_EQ) || (op_q > OP_NEG) || div0 || (num_mag == 64'd0);
  assign sts_o.gcd_done = (u_q == 64'd0);
  assign sts_o.div_done = (cnt_q == 7'd64);

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        op_q <= req_type_i;
        an_q <= a_num_i;
        ad_q <= a_den_i;
        bn_q <= b_num_i;
        bd_q <= b_den_i;
      end
      CMD_MUL0: begin
        prod_q  <= mx * my;
        psign_q <= mxs ^ mys;
      end
      CMD_MUL1: begin
        num_q   <= sprod;
        prod_q  <= mx * my;
        psign_q <= mxs ^ mys;
      end
      CMD_MUL2: begin
        num_q   <= num_q + sprod;
        prod_q  <= mx * my;
        psign_q <= mxs ^ mys;
      end
      CMD_MUL3: begin
        den_q   <= prod_q;
        dsign_q <= psign_q;
      end
      CMD_GCD_INIT: begin
        u_q <= num_mag;
        v_q <= den_q;
        k_q <= 6'd0;
      end
      CMD_GCD_STEP: begin
        if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + 6'd1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= u_q - v_q;
        end else begin
          v_q <= v_q - u_q;
        end
      end
      CMD_DIVN_INIT: begin
        gd_q  <= gcd_val;
        dvd_q <= num_mag;
        rem_q <= 64'd0;
        cnt_q <= 7'd0;
      end
      CMD_DIVD_INIT: begin
        qn_q  <= dvd_q;
        dvd_q <= den_q;
        rem_q <= 64'd0;
        cnt_q <= 7'd0;
      end
      CMD_DIV_STEP: begin
        rem_q <= ge ? 64'(rs - {1'b0, gd_q}) : rs[63:0];
        dvd_q <= {dvd_q[62:0], ge};
        cnt_q <= cnt_q + 7'd1;
      end
      CMD_FINISH: begin
        res_num_q <= 32'd0;
        res_den_q <= 31'd1;
        eq_q      <= 1'b0;
        st_q      <= ST_OK;
        if (op_q == OP_EQ) begin
          eq_q <= eq;
        end else if (op_q > OP_NEG) begin
          st_q <= ST_OK;
        end else if (div0) begin
          st_q <= ST_DIV0;
        end else if (num_mag == 64'd0) begin
          st_q <= ST_OK;
        end else if (ovf) begin
          st_q <= ST_OVF;
        end else begin
          res_num_q <= neg ? (32'd0 - qn_q[31:0]) : qn_q[31:0];
          res_den_q <= qd[30:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign res_num_o  = res_num_q;
  assign res_den_o  = res_den_q;
  assign is_equal_o = eq_q;
  assign status_o   = st_q;

endmodule

// File: rtl/core/rau_ctrl.sv
// controller: sequences the datapath and owns both handshakes
module rau_ctrl import rau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_e cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_CHK, S_GCD, S_DIVN, S_DIVD, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o   = CMD_LOAD;
        state_d = S_M0;
      end
      S_M0: begin
        cmd_o   = CMD_MUL0;
        state_d = S_M1;
      end
      S_M1: begin
        cmd_o   = CMD_MUL1;
        state_d = S_M2;
      end
      S_M2: begin
        cmd_o   = CMD_MUL2;
        state_d = S_M3;
      end
      S_M3: begin
        cmd_o   = CMD_MUL3;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (sts_i.trivial) begin
          state_d = S_FIN;
        end else begin
          cmd_o   = CMD_GCD_INIT;
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o   = CMD_DIVN_INIT;
          state_d = S_DIVN;
        end else begin
          cmd_o = CMD_GCD_STEP;
        end
      end
      S_DIVN: begin
        if (sts_i.div_done) begin
          cmd_o   = CMD_DIVD_INIT;
          state_d = S_DIVD;
        end else begin
          cmd_o = CMD_DIV_STEP;
        end
      end
      S_DIVD: begin
        if (sts_i.div_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o = CMD_DIV_STEP;
        end
      end
      S_FIN: if (out_free) begin
        cmd_o   = CMD_FINISH;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o == CMD_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/rational_arithmetic_unit.sv
// top level of the rational arithmetic unit
//
// input channel: in_valid_i / in_stall_o with req_type_i and the two fractions
// a_num_i/a_den_i and b_num_i/b_den_i; one transaction per operation
// output channel: out_valid_o / out_stall_i with res_num_o, res_den_o,
// is_equal_o and status_o; exactly one result transaction per input
// one operation at a time: the input is stalled from acceptance until the
// result is written into the output register
// compare, error and zero results go from the products straight to the
// result write; otherwise the binary gcd over the 64-bit numerator and
// denominator runs, each step a halving or a subtract and compare, and the
// restoring divider then divides both by it, one quotient bit a cycle
// the cross products come from one shared 32x32 multiplier, one at a time
// a stalled result holds in the output register while the next operation
// is accepted and computed; it is only overwritten once taken
// reset clears the controller and the output valid; no clearing pass
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int PART_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] a_num_i,
  input  logic [30:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [30:0] b_den_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] res_num_o,
  output logic [30:0] res_den_o,
  output logic        is_equal_o,
  output logic [1:0]  status_o
);

  cmd_e cmd;
  sts_t sts;

  // sequencing of load, multiply, gcd, divide and result write
  rau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and the output register
  rau_dp #(.PART_WIDTH(PART_WIDTH)) u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .req_type_i(req_type_i),
    .a_num_i   (a_num_i),
    .a_den_i   (a_den_i),
    .b_num_i   (b_num_i),
    .b_den_i   (b_den_i),
    .sts_o     (sts),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o),
    .is_equal_o(is_equal_o),
    .status_o  (status_o)
  );

endmodule

// File: rtl/core/rau_chk.sv
// port-level checker for the rational arithmetic unit and its bind
module rau_chk import rau_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] res_num_o,
  input logic [30:0] res_den_o,
  input logic        is_equal_o,
  input logic [1:0]  status_o
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // denominator never zero on a result
  a_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> res_den_o != 31'd0)
    else $error("zero denominator");

  // errors return zero over one
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> res_num_o == 32'd0 && res_den_o == 31'd1)
    else $error("error result not 0/1");

  // an equal flag only comes from a clean compare
  a_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_equal_o |-> status_o == ST_OK && res_num_o == 32'd0)
    else $error("bad compare result");

endmodule

bind rational_arithmetic_unit rau_chk u_rau_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .res_num_o  (res_num_o),
  .res_den_o  (res_den_o),
  .is_equal_o (is_equal_o),
  .status_o   (status_o)
);

// File: sim/rational_arithmetic_unit_checker.sv
// result checker of the rational arithmetic unit: predicts and compares results
`timescale 1ns / 1ps
module rational_arithmetic_unit_checker import rau_pkg::*; #(
  parameter int PART_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] a_num_i,
  input  logic [30:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [30:0] b_den_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] res_num_i,
  input  logic [30:0] res_den_i,
  input  logic        is_equal_i,
  input  logic [1:0]  status_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic        eq;
    logic [1:0]  st;
  } fraction_res_t;

  fraction_res_t expected_q[$];

  function automatic fraction_res_t bad_result(logic [1:0] st);
    fraction_res_t r;
    r.num = '0;
    r.den = 31'd1;
    r.eq  = 1'b0;
    r.st  = st;
    return r;
  endfunction

  function automatic logic [63:0] gcd_u64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // reduce num/den, sign onto the numerator, overflow check at PART_WIDTH
  function automatic fraction_res_t reduce(longint num, longint den);
    fraction_res_t r;
    logic neg;
    logic [63:0] n, d, g, lim;
    neg = 1'b0;
    n = num;
    d = den;
    if (num < 0) begin
      neg = ~neg;
      n = -num;
    end
    if (den < 0) begin
      neg = ~neg;
      d = -den;
    end
    if (n == 0) return bad_result(ST_OK);
    g = gcd_u64(n, d);
    n = n / g;
    d = d / g;
    lim = (64'd1 << (PART_WIDTH - 1)) - 1;
    if (d > lim || n > (neg ? lim + 1 : lim)) return bad_result(ST_OVF);
    r.num = neg ? 32'(-n) : 32'(n);
    r.den = 31'(d);
    r.eq  = 1'b0;
    r.st  = ST_OK;
    return r;
  endfunction

  function automatic fraction_res_t predict_fraction(logic [2:0] op, logic [31:0] anr,
      logic [30:0] adr, logic [31:0] bnr, logic [30:0] bdr);
    longint an, ad, bn, bd;
    fraction_res_t r;
    an = longint'($signed(anr));
    bn = longint'($signed(bnr));
    ad = longint'(adr);
    bd = longint'(bdr);
    case (op)
      OP_ADD: r = (ad == 0 || bd == 0) ? bad_result(ST_DIV0) : reduce(an * bd + bn * ad, ad * bd);
      OP_SUB: r = (ad == 0 || bd == 0) ? bad_result(ST_DIV0) : reduce(an * bd - bn * ad, ad * bd);
      OP_MUL: r = (ad == 0 || bd == 0) ? bad_result(ST_DIV0) : reduce(an * bn, ad * bd);
      OP_DIV: r = (ad == 0 || bd == 0 || bn == 0) ? bad_result(ST_DIV0)
                                                  : reduce(an * bd, ad * bn);
      OP_EQ: begin
        r = bad_result(ST_OK);
        r.eq = (anr == bnr && adr == bdr);
      end
      OP_NEG: r = (ad == 0) ? bad_result(ST_DIV0) : reduce(-an, ad);
      default: r = bad_result(ST_OK);
    endcase
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    fraction_res_t exp_r;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      // result side first so that a same-edge input never matches itself
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no expectation");
          errs++;
        end else begin
          exp_r = expected_q.pop_front();
          if (res_num_i !== exp_r.num) begin
            $error("res_num expected %h actual %h", exp_r.num, res_num_i);
            errs++;
          end
          if (res_den_i !== exp_r.den) begin
            $error("res_den expected %h actual %h", exp_r.den, res_den_i);
            errs++;
          end
          if (is_equal_i !== exp_r.eq) begin
            $error("is_equal expected %b actual %b", exp_r.eq, is_equal_i);
            errs++;
          end
          if (status_i !== exp_r.st) begin
            $error("status expected %0d actual %0d", exp_r.st, status_i);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(predict_fraction(req_type_i, a_num_i, a_den_i, b_num_i, b_den_i));
    end
  end

endmodule

// File: sim/rational_arithmetic_unit_tb.sv
// testbench top of the rational arithmetic unit: stimulus and verdict
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb import rau_pkg::*;;

  localparam int NUM_RANDOM = 900;
  localparam int CYCLE_LIMIT = 1500000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  req_type;
  logic [31:0] a_num;
  logic [30:0] a_den;
  logic [31:0] b_num;
  logic [30:0] b_den;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic        is_equal;
  logic [1:0]  status;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  logic        quiet_phase;   // no idling on either side
  logic        hold_off;      // long receiver stall, block fills up

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  rational_arithmetic_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .req_type_i  (req_type),
    .a_num_i     (a_num),
    .a_den_i     (a_den),
    .b_num_i     (b_num),
    .b_den_i     (b_den),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .res_num_o   (res_num),
    .res_den_o   (res_den),
    .is_equal_o  (is_equal),
    .status_o    (status)
  );

  rational_arithmetic_unit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .req_type_i   (req_type),
    .a_num_i      (a_num),
    .a_den_i      (a_den),
    .b_num_i      (b_num),
    .b_den_i      (b_den),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .res_num_i    (res_num),
    .res_den_i    (res_den),
    .is_equal_i   (is_equal),
    .status_i     (status),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rational_arithmetic_unit test failed");
      $finish;
    end
  end

  // receiver: random stalls, none while quiet, solid while holding off
  always @(posedge clk_i) begin
    if (hold_off) out_stall <= 1'b1;
    else if (quiet_phase) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 8);
  end

  // pressure: receiver holds off for a long stretch
  initial begin
    hold_off = 1'b0;
    wait (cycle_count == 30000);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // random fraction part; small values mostly so results reduce often
  function automatic logic [31:0] pick_num();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(40)) - 20);
      2: return $urandom() & 32'h8000_00ff;
      3: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  function automatic logic [30:0] pick_den();
    case ($urandom_range(6))
      0: return 31'($urandom());
      1: return 31'd1;
      2: return 31'h7fff_ffff;
      3: return 31'd0;
      4: return 31'($urandom_range(65535) + 1);
      default: return 31'($urandom_range(60) + 1);
    endcase
  endfunction

  // offer one transaction, a random idle gap before it unless in the quiet phase
  task automatic send_fraction(logic [2:0] op, logic [31:0] an, logic [30:0] ad,
                               logic [31:0] bn, logic [30:0] bd);
    if (!quiet_phase) begin
      while ($urandom_range(99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    req_type <= op;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  initial begin
    logic [2:0]  op;
    logic [31:0] an;
    logic [30:0] ad;
    quiet_phase = 1'b0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    req_type = OP_ADD;
    a_num = '0;
    a_den = 31'd1;
    b_num = '0;
    b_den = 31'd1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every operation, extremes and the named special cases
    send_fraction(OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
    send_fraction(OP_ADD, 32'h7fff_ffff, 31'd1, 32'd1, 31'd1);          // overflow
    send_fraction(OP_ADD, 32'd1, 31'd2, 32'hffff_ffff, 31'd2);          // zero result
    send_fraction(OP_SUB, 32'h8000_0000, 31'd1, 32'd1, 31'd1);          // overflow low
    send_fraction(OP_SUB, 32'h8000_0000, 31'd1, 32'd0, 31'd1);          // most negative
    send_fraction(OP_MUL, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    send_fraction(OP_MUL, 32'd6, 31'd4, 32'd2, 31'd9);                  // unreduced inputs
    send_fraction(OP_DIV, 32'd3, 31'd4, 32'd0, 31'd1);                  // divide by zero
    send_fraction(OP_DIV, 32'd3, 31'd4, 32'hffff_fffe, 31'd5);          // negative divisor
    send_fraction(OP_DIV, 32'h8000_0000, 31'd1, 32'hffff_ffff, 31'd1);  // negation overflow
    send_fraction(OP_ADD, 32'd1, 31'd0, 32'd1, 31'd1);                  // zero denominator
    send_fraction(OP_MUL, 32'd1, 31'd1, 32'd1, 31'd0);
    send_fraction(OP_EQ, 32'd5, 31'd7, 32'd5, 31'd7);
    send_fraction(OP_EQ, 32'd5, 31'd7, 32'd5, 31'd8);
    send_fraction(OP_EQ, 32'd0, 31'd0, 32'd0, 31'd0);                   // compare ignores zero den
    send_fraction(OP_NEG, 32'h8000_0000, 31'd1, 32'd0, 31'd1);          // overflow
    send_fraction(OP_NEG, 32'h7fff_ffff, 31'h7fff_ffff, 32'd0, 31'd1);
    send_fraction(OP_NEG, 32'd3, 31'd0, 32'd0, 31'd1);
    send_fraction(3'd6, 32'd1, 31'd1, 32'd1, 31'd1);                    // unused op codes
    send_fraction(3'd7, 32'hffff_ffff, 31'h7fff_ffff, 32'hffff_ffff, 31'h7fff_ffff);

    // random part, with a stretch of no idling in the middle
    for (int i = 0; i < NUM_RANDOM; i++) begin
      quiet_phase <= (i >= 300 && i < 420);
      op = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      an = pick_num();
      ad = pick_den();
      if (op == OP_EQ && $urandom_range(1))
        send_fraction(op, an, ad, an, ad);
      else
        send_fraction(op, an, ad, pick_num(), pick_den());
    end
    in_valid <= 1'b0;
    quiet_phase <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (fail_count == 0)
      $display("rational_arithmetic_unit test passed");
    else
      $display("rational_arithmetic_unit test failed");
    $finish;
  end

endmodule

// File: files.f
rtl/core/rau_pkg.sv
rtl/core/rau_dp.sv
rtl/core/rau_ctrl.sv
rtl/core/rational_arithmetic_unit.sv
rtl/core/rau_chk.sv
sim/rational_arithmetic_unit_checker.sv
sim/rational_arithmetic_unit_tb.sv
